/* src/pu_pkg.sv */
// ----------------------------------------------------------------------------
// pu_pkg
// Shared types, constants and the factorial table for the permutation
// unrank unit.
// ----------------------------------------------------------------------------
package pu_pkg;

  // field widths fixed by the transaction format
  localparam int COUNT_W = 4;
  localparam int RANK_W  = 19;
  localparam int ELEM_W  = 4;
  // 12! is the largest factorial needed and fits in 29 bits
  localparam int FACT_W  = 29;

  localparam int MAX_ELEMENTS_DEF = 9;

  // request transaction
  typedef struct packed {
    logic [COUNT_W-1:0] element_count;
    logic [RANK_W-1:0]  rank;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [ELEM_W-1:0] element_value;
    logic              is_last;
    logic              rank_error;
  } rsp_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               err;
    logic [COUNT_W-1:0] count;
    logic [RANK_W-1:0]  rem;
  } cmd_t;

  // m! for m = 0..12; larger codes never reach a valid command
  function automatic logic [FACT_W-1:0] fact_of(input logic [COUNT_W-1:0] m);
    logic [FACT_W-1:0] f;
    case (m)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

/* src/pu_front.sv */
// ----------------------------------------------------------------------------
// pu_front
// Classifies a request: checks count and rank range and forms the
// zero-based rank for the back end.
// ----------------------------------------------------------------------------
module pu_front
  import pu_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  req_t req,
  output cmd_t cmd
);

  logic              count_bad;
  logic              rank_bad;
  logic [FACT_W-1:0] n_fact;

  // range checks
  always_comb begin
    n_fact    = fact_of(req.element_count);
    count_bad = (req.element_count == '0) ||
                (req.element_count > COUNT_W'(MAX_ELEMENTS));
    rank_bad  = (req.rank == '0) ||
                ({{(FACT_W-RANK_W){1'b0}}, req.rank} > n_fact);
  end

  // command fields
  always_comb begin
    cmd.err   = count_bad || rank_bad;
    cmd.count = req.element_count;
    cmd.rem   = req.rank - RANK_W'(1);
  end

endmodule

/* src/pu_queue.sv */
// ----------------------------------------------------------------------------
// pu_queue
// Two-entry command queue between front and back; lets the request side
// keep accepting while the back end works.
// ----------------------------------------------------------------------------
module pu_queue
  import pu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign pop_cmd = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_cmd;
  end

endmodule

/* src/pu_back.sv */
// ----------------------------------------------------------------------------
// pu_back
// Unranks one command: finds each digit by repeated factorial subtraction,
// emits the chosen pool element and closes the gap in the pool.
// ----------------------------------------------------------------------------
module pu_back
  import pu_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int QW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]         state;
  logic               err;
  logic [COUNT_W-1:0] left;
  logic [RANK_W-1:0]  rem;
  logic [FACT_W-1:0]  fact;
  logic [QW-1:0]      q;
  logic [ELEM_W-1:0]  pool [MAX_ELEMENTS];

  logic               out_free;
  logic               sub_ok;

  // output register is free when empty or being drained
  assign out_free = !rsp_valid || !rsp_stall;
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;

  // one more subtraction fits and the digit stays below the pool size
  assign sub_ok = ({{(FACT_W-RANK_W){1'b0}}, rem} >= fact) &&
                  (COUNT_W'(q) < (left - COUNT_W'(1)));

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // result register: load on emit, clear once taken
      if (state == ST_EMIT && out_free) rsp_valid <= 1'b1;
      else if (!rsp_stall)              rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) state <= cmd.err ? ST_EMIT : ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (!sub_ok) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (err || left == COUNT_W'(1)) state <= ST_IDLE;
            else                            state <= ST_DIVIDE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          err  <= cmd.err;
          left <= cmd.count;
          rem  <= cmd.rem;
          fact <= fact_of(cmd.count - COUNT_W'(1));
          q    <= '0;
          for (int i = 0; i < MAX_ELEMENTS; i++) begin
            pool[i] <= ELEM_W'(i + 1);
          end
        end
      end
      ST_DIVIDE: begin
        if (sub_ok) begin
          rem <= rem - fact[RANK_W-1:0];
          q   <= q + QW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (err) begin
            rsp.element_value <= '0;
            rsp.is_last       <= 1'b1;
            rsp.rank_error    <= 1'b1;
          end else begin
            rsp.element_value <= pool[q];
            rsp.is_last       <= (left == COUNT_W'(1));
            rsp.rank_error    <= 1'b0;
            // close the gap left by the chosen element
            for (int j = 0; j < MAX_ELEMENTS - 1; j++) begin
              if (QW'(j) >= q) pool[j] <= pool[j+1];
            end
            left <= left - COUNT_W'(1);
            fact <= fact_of(left - COUNT_W'(2));
            q    <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/permutation_unrank_unit.sv */
// Flow: a request is registered in the queue and waits there until the back
// end is idle; each element's digit q (0..m-1, m elements left) is then found
// by repeated factorial subtraction. The back end takes a new request only
// after the last result of the previous one; an error request gives one result.
// Reset: rst, synchronous, empties the queue and the output register.
// ----------------------------------------------------------------------------
// permutation_unrank_unit
// Emits the k-th lexicographic permutation of 1..n, one element per result.
// ----------------------------------------------------------------------------
module permutation_unrank_unit
  import pu_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_empty;
  logic queue_pop;
  logic queue_push;

  // request side: accept whenever the queue has room
  assign req_stall  = queue_full;
  assign queue_push = req_valid && !queue_full;

  pu_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .req(req),
    .cmd(front_cmd)
  );

  pu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (queue_push),
    .push_cmd(front_cmd),
    .full    (queue_full),
    .pop     (queue_pop),
    .pop_cmd (queue_cmd),
    .empty   (queue_empty)
  );

  pu_back #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(!queue_empty),
    .cmd      (queue_cmd),
    .cmd_pop  (queue_pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

endmodule
